/* design/e2q_pkg.sv */
// Shared types, formats and constants for the Euler-to-quaternion converter.
package e2q_pkg;

    // Fixed formats of the ports.
    localparam int ANG_W           = 16;
    localparam int OUT_W           = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS   = 15;

    // CORDIC depth: default and the depth of the arctangent table.
    localparam int TRIG_ITER_DEF = 16;
    localparam int TRIG_ITER_MAX = 32;

    // Half angle in Q.32 radians: 16 input bits shifted up by 31 - ANGLE_FRAC_BITS.
    localparam int H_W   = ANG_W + 31 - ANGLE_FRAC_BITS;
    localparam int Z_W   = 35;          // residual angle, Q.32, covers +-pi/2 plus growth
    localparam int XY_W  = 32;          // sine / cosine, Q.30
    localparam int XY_FRAC = 30;
    localparam int PROD_W  = 64;        // Q.60 products

    localparam longint PI_Q32      = 64'sd13493037705;
    localparam longint PI_HALF_Q32 = PI_Q32 / 2;
    localparam longint H_ABS_MAX   = longint'(1) << (H_W - 1);

    // Largest multiple of pi that the range reduction can remove.
    localparam int N_MAX = int'((H_ABS_MAX + PI_HALF_Q32) / PI_Q32);
    localparam int CNT_W = $clog2(N_MAX + 1);

    localparam int RND_SHIFT = 2 * XY_FRAC - OUT_FRAC_BITS;

    // Pipeline depths outside the CORDIC chain.
    localparam int HSC_FIXED_LAT = 3;   // two reduction stages, one sign fix stage
    localparam int CMB_LAT       = 5;   // product, round, product, sum, saturate

    typedef logic signed [ANG_W-1:0]  t_angle;
    typedef logic signed [OUT_W-1:0]  t_quat;
    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [Z_W-1:0]    t_z;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_xy sn;
        t_xy cs;
    } t_sincos;

    localparam t_xy GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in Q.32, rounded.
    localparam t_z ATAN_Q32 [TRIG_ITER_MAX] = '{
        35'sd3373259426, 35'sd1991351318, 35'sd1052175346, 35'sd534100635,
        35'sd268086748,  35'sd134174063,  35'sd67103403,   35'sd33553749,
        35'sd16777131,   35'sd8388597,    35'sd4194303,    35'sd2097152,
        35'sd1048576,    35'sd524288,     35'sd262144,     35'sd131072,
        35'sd65536,      35'sd32768,      35'sd16384,      35'sd8192,
        35'sd4096,       35'sd2048,       35'sd1024,       35'sd512,
        35'sd256,        35'sd128,        35'sd64,         35'sd32,
        35'sd16,         35'sd8,          35'sd4,          35'sd2
    };

endpackage

/* design/e2q_cordic_cell.sv */
// One rotation-mode CORDIC micro-rotation, registered.
module e2q_cordic_cell
    import e2q_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_xy  i_x,
    input  t_xy  i_y,
    input  t_z   i_z,
    input  logic i_odd,
    output t_xy  o_x,
    output t_xy  o_y,
    output t_z   o_z,
    output logic o_odd
);

    localparam t_z ATAN = ATAN_Q32[SHIFT];

    t_xy  r_x, n_x;
    t_xy  r_y, n_y;
    t_z   r_z, n_z;
    logic r_odd;
    t_xy  w_dx, w_dy;

    always_comb begin
        w_dx = i_y >>> SHIFT;
        w_dy = i_x >>> SHIFT;
        if (!i_z[Z_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_odd <= i_odd;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_odd = r_odd;

endmodule

/* design/e2q_half_sincos.sv */
// Sine and cosine of half an input angle: range reduction, CORDIC chain, sign fix.
module e2q_half_sincos
    import e2q_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_angle  i_angle,
    output t_sincos o_sc
);

    logic signed [H_W-1:0] w_h;
    logic [H_W-1:0]        w_habs;
    logic [CNT_W-1:0]      w_cnt;

    logic [H_W-1:0]   r_habs;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;

    t_z   w_red;
    t_z   r_z0;
    logic r_odd0;

    t_xy  w_x   [TRIG_ITERATIONS+1];
    t_xy  w_y   [TRIG_ITERATIONS+1];
    t_z   w_z   [TRIG_ITERATIONS];
    logic w_odd [TRIG_ITERATIONS+1];

    t_sincos r_sc;

    // Stage 1: half angle, magnitude, nearest multiple of pi (halves away from zero).
    assign w_h    = {i_angle, {(31 - ANGLE_FRAC_BITS){1'b0}}};
    assign w_habs = w_h[H_W-1] ? H_W'(-w_h) : H_W'(w_h);

    always_comb begin
        w_cnt = '0;
        for (int k = 1; k <= N_MAX; k++) begin
            if (longint'(w_habs) >= longint'(k) * PI_Q32 - PI_HALF_Q32) begin
                w_cnt = w_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_habs <= w_habs;
            r_neg  <= w_h[H_W-1];
            r_cnt  <= w_cnt;
        end
    end

    // Stage 2: residual angle within +-pi/2, sign restored.
    assign w_red = Z_W'(longint'(r_habs) - longint'(r_cnt) * PI_Q32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0   <= r_neg ? -w_red : w_red;
            r_odd0 <= r_cnt[0];
        end
    end

    assign w_x[0]   = GAIN_Q30;
    assign w_y[0]   = '0;
    assign w_z[0]   = r_z0;
    assign w_odd[0] = r_odd0;

    for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_cell
        if (k < TRIG_ITERATIONS - 1) begin : g_mid
            e2q_cordic_cell #(.SHIFT(k)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_x   (w_x[k]),
                .i_y   (w_y[k]),
                .i_z   (w_z[k]),
                .i_odd (w_odd[k]),
                .o_x   (w_x[k+1]),
                .o_y   (w_y[k+1]),
                .o_z   (w_z[k+1]),
                .o_odd (w_odd[k+1])
            );
        end else begin : g_last
            e2q_cordic_cell #(.SHIFT(k)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_x   (w_x[k]),
                .i_y   (w_y[k]),
                .i_z   (w_z[k]),
                .i_odd (w_odd[k]),
                .o_x   (w_x[k+1]),
                .o_y   (w_y[k+1]),
                .o_z   (),
                .o_odd (w_odd[k+1])
            );
        end
    end

    // Odd multiple of pi flips both sine and cosine.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc.sn <= w_odd[TRIG_ITERATIONS] ? -w_y[TRIG_ITERATIONS] : w_y[TRIG_ITERATIONS];
            r_sc.cs <= w_odd[TRIG_ITERATIONS] ? -w_x[TRIG_ITERATIONS] : w_x[TRIG_ITERATIONS];
        end
    end

    assign o_sc = r_sc;

endmodule

/* design/e2q_combine.sv */
// ZYX quaternion products, rounding and saturation.
module e2q_combine
    import e2q_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_sincos i_roll,
    input  t_sincos i_pitch,
    input  t_sincos i_yaw,
    output t_quat   o_quat_x,
    output t_quat   o_quat_y,
    output t_quat   o_quat_z,
    output t_quat   o_quat_w
);

    localparam t_prod RND_AB  = t_prod'(1) <<< (XY_FRAC - 1);
    localparam t_prod RND_OUT = t_prod'(1) <<< (RND_SHIFT - 1);
    localparam t_prod OUT_MAX = 64'sd32767;

    t_prod r_p  [4];
    t_xy   r_cy1, r_sy1, r_cy2, r_sy2;
    t_prod w_pr [4];
    t_xy   r_ab [4];
    t_prod r_t  [8];
    t_prod r_s  [4];
    t_prod w_v  [4];
    t_quat n_q  [4];
    t_quat r_q  [4];

    // Stage 1: roll x pitch pairs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= t_prod'(i_roll.sn) * t_prod'(i_pitch.cs);
            r_p[1] <= t_prod'(i_roll.cs) * t_prod'(i_pitch.sn);
            r_p[2] <= t_prod'(i_roll.cs) * t_prod'(i_pitch.cs);
            r_p[3] <= t_prod'(i_roll.sn) * t_prod'(i_pitch.sn);
            r_cy1  <= i_yaw.cs;
            r_sy1  <= i_yaw.sn;
        end
    end

    // Stage 2: round pairs back to Q.30.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pr[k] = r_p[k] + RND_AB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_ab[k] <= w_pr[k][XY_FRAC +: XY_W];
            end
            r_cy2 <= r_cy1;
            r_sy2 <= r_sy1;
        end
    end

    // Stage 3: times the yaw terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t[0] <= t_prod'(r_ab[0]) * t_prod'(r_cy2);
            r_t[1] <= t_prod'(r_ab[1]) * t_prod'(r_sy2);
            r_t[2] <= t_prod'(r_ab[1]) * t_prod'(r_cy2);
            r_t[3] <= t_prod'(r_ab[0]) * t_prod'(r_sy2);
            r_t[4] <= t_prod'(r_ab[2]) * t_prod'(r_sy2);
            r_t[5] <= t_prod'(r_ab[3]) * t_prod'(r_cy2);
            r_t[6] <= t_prod'(r_ab[2]) * t_prod'(r_cy2);
            r_t[7] <= t_prod'(r_ab[3]) * t_prod'(r_sy2);
        end
    end

    // Stage 4: x, y, z, w sums with the output rounding offset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= r_t[0] - r_t[1] + RND_OUT;
            r_s[1] <= r_t[2] + r_t[3] + RND_OUT;
            r_s[2] <= r_t[4] - r_t[5] + RND_OUT;
            r_s[3] <= r_t[6] + r_t[7] + RND_OUT;
        end
    end

    // Stage 5: scale and clamp to +-32767.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k] = r_s[k] >>> RND_SHIFT;
            if (w_v[k] > OUT_MAX) begin
                n_q[k] = OUT_W'(OUT_MAX);
            end else if (w_v[k] < -OUT_MAX) begin
                n_q[k] = OUT_W'(-OUT_MAX);
            end else begin
                n_q[k] = w_v[k][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_q[k] <= n_q[k];
            end
        end
    end

    assign o_quat_x = r_q[0];
    assign o_quat_y = r_q[1];
    assign o_quat_z = r_q[2];
    assign o_quat_w = r_q[3];

endmodule

/* design/euler_to_quaternion_unit.sv */
// Top level: Euler angles (ZYX) to unit quaternion, fully pipelined.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_roll_angle, i_pitch_angle, i_yaw_angle
//  out     | output    | o_out_valid / i_out_ready | o_quat_x, o_quat_y, o_quat_z, o_quat_w
//
//  One transaction per cycle sustained while no stall holds the pipeline.
//  The pipeline runs through range reduction, the CORDIC chain with one cell per
//  micro-rotation, the sign fix, then the products and rounding.
//  Stall: the whole pipeline holds while a result waits and i_out_ready is low.
//  Reset (i_rst_n low, synchronous) empties the pipeline; data registers are not reset.
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_angle i_roll_angle,
    input  t_angle i_pitch_angle,
    input  t_angle i_yaw_angle,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_quat  o_quat_x,
    output t_quat  o_quat_y,
    output t_quat  o_quat_z,
    output t_quat  o_quat_w
);

    localparam int LAT = HSC_FIXED_LAT + TRIG_ITERATIONS + CMB_LAT;

    // Pipeline advances whenever the output slot is empty or being drained.
    logic           w_en;
    logic [LAT-1:0] r_vld, n_vld;

    t_sincos w_roll, w_pitch, w_yaw;

    assign w_en       = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = w_en;
    assign o_out_valid = r_vld[LAT-1];

    // Valid bits shadow the data pipeline stage for stage.
    always_comb begin
        n_vld = r_vld;
        if (w_en) begin
            n_vld = {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Three independent half-angle sine/cosine chains.
    e2q_half_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_roll_angle),
        .o_sc    (w_roll)
    );

    e2q_half_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_pitch_angle),
        .o_sc    (w_pitch)
    );

    e2q_half_sincos #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_yaw_angle),
        .o_sc    (w_yaw)
    );

    // Products, rounding, saturation; its last stage is the output register.
    e2q_combine u_combine (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_roll   (w_roll),
        .i_pitch  (w_pitch),
        .i_yaw    (w_yaw),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // Norm check only meaningful when the output format is Q1.15.
    localparam bit     NORM_CHECK = (OUT_FRAC_BITS == OUT_W - 1);
    localparam longint NORM_ONE   = longint'(1) << (2 * OUT_FRAC_BITS);
    localparam longint NORM_TOL   = NORM_ONE >> 9;

    logic signed [31:0] w_sq [4];
    logic signed [33:0] w_norm;

    assign w_sq[0] = 32'(o_quat_x) * 32'(o_quat_x);
    assign w_sq[1] = 32'(o_quat_y) * 32'(o_quat_y);
    assign w_sq[2] = 32'(o_quat_z) * 32'(o_quat_z);
    assign w_sq[3] = 32'(o_quat_w) * 32'(o_quat_w);
    assign w_norm  = 34'(w_sq[0]) + 34'(w_sq[1]) + 34'(w_sq[2]) + 34'(w_sq[3]);

    // Pipeline is empty right after reset is released.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Saturation never yields the most negative code.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quat_x != 16'sh8000) && (o_quat_y != 16'sh8000) &&
                        (o_quat_z != 16'sh8000) && (o_quat_w != 16'sh8000))
        else $error("quaternion component at -32768");

    // Result must be a unit quaternion within rounding error.
    a_unit_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NORM_CHECK && o_out_valid) |->
            (longint'(w_norm) > NORM_ONE - NORM_TOL) &&
            (longint'(w_norm) < NORM_ONE + NORM_TOL))
        else $error("quaternion norm off unity");

endmodule
